>>> src/ttis_pkg.sv
// ----------------------------------------------------------------------------
// ttis_pkg: shared types and constants of the two-track intercept solver
// Fixed-point widths, result codes, queue item layout and the sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package ttis_pkg;

    // fixed-point formats
    localparam int TRIG_FRAC_BITS = 15;
    localparam int POS_FRAC_BITS  = 8;
    localparam int TIME_FRAC_BITS = 4;

    localparam int POS_W   = 18;
    localparam int HEAD_W  = 12;
    localparam int SPEED_W = 11;
    localparam int TIME_W  = 20;
    localparam int TRIG_W  = TRIG_FRAC_BITS + 1;
    localparam int VEL_W   = 28;
    localparam int NE_W    = 27;
    localparam int M_W     = 18;
    localparam int ADDR_W  = 10;

    // heading folding
    localparam logic [HEAD_W-1:0] FULL_TURN = 12'd3600;
    localparam logic [HEAD_W-1:0] QUARTER   = 12'd900;
    localparam logic [HEAD_W-1:0] HALF      = 12'd1800;
    localparam logic [HEAD_W-1:0] THREE_Q   = 12'd2700;
    localparam int                TAB_LAST  = 900;

    // result codes
    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_NO_ROOT  = 2'd2;
    localparam logic [1:0] ST_PAST     = 2'd3;

    // parallel test: |E|^2 * 10^6 < 1296 * 4^TRIG_FRAC_BITS
    localparam logic [51:0] PAR_LIM   = 52'd1296 << (2 * TRIG_FRAC_BITS);
    localparam logic [51:0] PAR_SCALE = 52'd1000000;

    // time numerator scale: 3600 * 2^(TRIG + TIME + 1 - POS)
    localparam logic [23:0] TIME_SCALE =
        24'(3600 << (TRIG_FRAC_BITS + TIME_FRAC_BITS + 1 - POS_FRAC_BITS));

    // divider shape
    localparam int DIV_Q_W   = 21;
    localparam int DEN_W     = NE_W + 1;
    localparam int TNUM_W    = 44;
    localparam int PNUM_W    = 49;

    localparam logic [TIME_W-1:0]       TIME_MAX = '1;
    localparam logic signed [POS_W-1:0] POS_MAX  = 18'sd131071;
    localparam logic signed [POS_W-1:0] POS_MIN  = -18'sd131072;

    localparam int QUEUE_DEPTH = 4;

    // one classified item handed from front to back
    typedef struct packed {
        logic [1:0]               status;
        logic signed [POS_W-1:0]  x1;
        logic signed [POS_W-1:0]  y1;
        logic signed [VEL_W-1:0]  vx1;
        logic signed [VEL_W-1:0]  vy1;
        logic [M_W-1:0]           m;
        logic [NE_W-1:0]          ne;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef logic [TRIG_W-1:0] t_sin_tab [0:TAB_LAST];

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // first-quadrant sine table in tenths of a degree, built at elaboration
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab    tab;
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        int          k;
        int          n;
        for (k = 0; k <= TAB_LAST; k++) begin
            theta = (64'(k) * PI_Q30 + 64'd900) / 64'd1800;
            x2    = (theta * theta) >> 30;
            term  = theta;
            sum   = longint'(theta);
            for (n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n & 1) != 0) sum = sum - longint'(term);
                else              sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
            tab[k] = TRIG_W'((sum + (longint'(1) << (29 - TRIG_FRAC_BITS)))
                             >>> (30 - TRIG_FRAC_BITS));
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

>>> src/ttis_if.sv
// ----------------------------------------------------------------------------
// ttis_if: track and result channels
// Valid/ready channels carrying a track pair in and an intercept result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttis_track_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [ttis_pkg::POS_W-1:0]         first_x;
    logic signed [ttis_pkg::POS_W-1:0]         first_y;
    logic        [ttis_pkg::HEAD_W-1:0]        first_heading;
    logic        [ttis_pkg::SPEED_W-1:0]       first_speed;
    logic signed [ttis_pkg::POS_W-1:0]         second_x;
    logic signed [ttis_pkg::POS_W-1:0]         second_y;
    logic        [ttis_pkg::HEAD_W-1:0]        second_heading;
    logic        [ttis_pkg::SPEED_W-1:0]       second_speed;

    modport source (
        output valid, first_x, first_y, first_heading, first_speed,
               second_x, second_y, second_heading, second_speed,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_heading, first_speed,
               second_x, second_y, second_heading, second_speed,
        output ready
    );
endinterface

interface ttis_result_if;
    logic                                valid;
    logic                                ready;
    logic        [1:0]                   status;
    logic signed [ttis_pkg::POS_W-1:0]   meet_x;
    logic signed [ttis_pkg::POS_W-1:0]   meet_y;
    logic        [ttis_pkg::TIME_W-1:0]  meet_time;

    modport source (output valid, status, meet_x, meet_y, meet_time, input ready);
    modport sink   (input  valid, status, meet_x, meet_y, meet_time, output ready);
endinterface

`default_nettype wire

>>> src/ttis_trig_rom.sv
// ----------------------------------------------------------------------------
// ttis_trig_rom: quarter-wave sine table
// Two read ports with registered data, one item step per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttis_trig_rom (
    input  wire                                i_clk,
    input  wire                                i_en,
    input  wire  [ttis_pkg::ADDR_W-1:0]        i_addr_a,
    input  wire  [ttis_pkg::ADDR_W-1:0]        i_addr_b,
    output logic [ttis_pkg::TRIG_W-1:0]        o_data_a,
    output logic [ttis_pkg::TRIG_W-1:0]        o_data_b
);

    localparam ttis_pkg::t_sin_tab SIN_TAB = ttis_pkg::build_sin_tab();

    // read both ports
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data_a <= SIN_TAB[i_addr_a];
            o_data_b <= SIN_TAB[i_addr_b];
        end
    end

endmodule

`default_nettype wire

>>> src/ttis_front.sv
// ----------------------------------------------------------------------------
// ttis_front: velocity and classification pipeline
// Folds headings, looks up sine and cosine, forms velocities, relative
// motion, the parallel and cross-product tests, and hands a job to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ttis_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    ttis_track_if.sink          i_track,
    input  ttis_pkg::t_qstat    i_qstat,
    output logic                o_push,
    output ttis_pkg::t_job      o_job
);

    localparam int PW = ttis_pkg::POS_W;
    localparam int VW = ttis_pkg::VEL_W;
    localparam int NW = ttis_pkg::NE_W;
    localparam int AW = ttis_pkg::ADDR_W;
    localparam int TW = ttis_pkg::TRIG_W;
    localparam int SW = ttis_pkg::SPEED_W;

    logic en;
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;

    assign en            = !r_v5 || !i_qstat.full;
    assign i_track.ready = en;
    assign o_push        = r_v5 && !i_qstat.full;

    // ---------------- stage 0: fold headings into quadrant and offset
    function automatic logic [AW+1:0] fold_heading(input logic [ttis_pkg::HEAD_W-1:0] h);
        logic [ttis_pkg::HEAD_W-1:0] hw;
        logic [ttis_pkg::HEAD_W-1:0] r;
        logic [1:0]                  q;
        hw = (h >= ttis_pkg::FULL_TURN) ? h - ttis_pkg::FULL_TURN : h;
        if (hw < ttis_pkg::QUARTER) begin
            q = 2'd0; r = hw;
        end else if (hw < ttis_pkg::HALF) begin
            q = 2'd1; r = hw - ttis_pkg::QUARTER;
        end else if (hw < ttis_pkg::THREE_Q) begin
            q = 2'd2; r = hw - ttis_pkg::HALF;
        end else begin
            q = 2'd3; r = hw - ttis_pkg::THREE_Q;
        end
        return {q, r[AW-1:0]};
    endfunction

    logic [AW+1:0] f1, f2;
    assign f1 = fold_heading(i_track.first_heading);
    assign f2 = fold_heading(i_track.second_heading);

    logic [1:0]              r0_q1, r0_q2;
    logic [AW-1:0]           r0_r1, r0_r2;
    logic signed [PW-1:0]    r0_x1, r0_y1, r0_x2, r0_y2;
    logic [SW-1:0]           r0_sp1, r0_sp2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_q1  <= f1[AW+1:AW];
            r0_r1  <= f1[AW-1:0];
            r0_q2  <= f2[AW+1:AW];
            r0_r2  <= f2[AW-1:0];
            r0_x1  <= i_track.first_x;
            r0_y1  <= i_track.first_y;
            r0_x2  <= i_track.second_x;
            r0_y2  <= i_track.second_y;
            r0_sp1 <= i_track.first_speed;
            r0_sp2 <= i_track.second_speed;
        end
    end

    // ---------------- stage 1: table lookup
    logic [TW-1:0] sr1, cr1, sr2, cr2;

    ttis_trig_rom u_rom1 (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_addr_a (r0_r1),
        .i_addr_b (AW'(ttis_pkg::TAB_LAST) - r0_r1),
        .o_data_a (sr1),
        .o_data_b (cr1)
    );

    ttis_trig_rom u_rom2 (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_addr_a (r0_r2),
        .i_addr_b (AW'(ttis_pkg::TAB_LAST) - r0_r2),
        .o_data_a (sr2),
        .o_data_b (cr2)
    );

    logic [1:0]              r1_q1, r1_q2;
    logic signed [PW-1:0]    r1_x1, r1_y1, r1_x2, r1_y2;
    logic [SW-1:0]           r1_sp1, r1_sp2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_q1  <= r0_q1;
            r1_q2  <= r0_q2;
            r1_x1  <= r0_x1;
            r1_y1  <= r0_y1;
            r1_x2  <= r0_x2;
            r1_y2  <= r0_y2;
            r1_sp1 <= r0_sp1;
            r1_sp2 <= r0_sp2;
        end
    end

    // ---------------- stage 2: restore quadrant, scale by speed
    function automatic logic [2*TW+1:0] unfold(input logic [1:0] q,
                                               input logic [TW-1:0] sr,
                                               input logic [TW-1:0] cr);
        logic signed [TW:0] ps;
        logic signed [TW:0] pc;
        logic signed [TW:0] s;
        logic signed [TW:0] c;
        ps = $signed({1'b0, sr});
        pc = $signed({1'b0, cr});
        case (q)
            2'd0:    begin s = ps;  c = pc;  end
            2'd1:    begin s = pc;  c = -ps; end
            2'd2:    begin s = -ps; c = -pc; end
            default: begin s = -pc; c = ps;  end
        endcase
        return {s, c};
    endfunction

    logic [2*TW+1:0]      t1, t2;
    logic signed [TW:0]   s1, c1, s2, c2;
    logic signed [SW:0]   spx1, spx2;
    logic signed [VW:0]   pvx1, pvy1, pvx2, pvy2;

    assign t1   = unfold(r1_q1, sr1, cr1);
    assign t2   = unfold(r1_q2, sr2, cr2);
    assign s1   = $signed(t1[2*TW+1:TW+1]);
    assign c1   = $signed(t1[TW:0]);
    assign s2   = $signed(t2[2*TW+1:TW+1]);
    assign c2   = $signed(t2[TW:0]);
    assign spx1 = $signed({1'b0, r1_sp1});
    assign spx2 = $signed({1'b0, r1_sp2});
    assign pvx1 = s1 * spx1;
    assign pvy1 = c1 * spx1;
    assign pvx2 = s2 * spx2;
    assign pvy2 = c2 * spx2;

    logic signed [VW-1:0]  r2_vx1, r2_vy1, r2_vx2, r2_vy2;
    logic signed [PW-1:0]  r2_x1, r2_y1, r2_x2, r2_y2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_vx1 <= pvx1[VW-1:0];
            r2_vy1 <= pvy1[VW-1:0];
            r2_vx2 <= pvx2[VW-1:0];
            r2_vy2 <= pvy2[VW-1:0];
            r2_x1  <= r1_x1;
            r2_y1  <= r1_y1;
            r2_x2  <= r1_x2;
            r2_y2  <= r1_y2;
        end
    end

    // ---------------- stage 3: relative motion
    logic signed [VW-1:0]  ex, ey;

    assign ex = r2_vx2 - r2_vx1;
    assign ey = r2_vy2 - r2_vy1;

    logic signed [VW-1:0]  r3_ex, r3_ey, r3_vx1, r3_vy1;
    logic [NW-1:0]         r3_ax, r3_ay;
    logic signed [PW:0]    r3_dx, r3_dy;
    logic signed [PW-1:0]  r3_x1, r3_y1;
    logic signed [VW-1:0]  aex, aey;

    assign aex = (ex < 0) ? -ex : ex;
    assign aey = (ey < 0) ? -ey : ey;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ex  <= ex;
            r3_ey  <= ey;
            r3_ax  <= aex[NW-1:0];
            r3_ay  <= aey[NW-1:0];
            r3_dx  <= $signed({r2_x2[PW-1], r2_x2}) - $signed({r2_x1[PW-1], r2_x1});
            r3_dy  <= $signed({r2_y2[PW-1], r2_y2}) - $signed({r2_y1[PW-1], r2_y1});
            r3_vx1 <= r2_vx1;
            r3_vy1 <= r2_vy1;
            r3_x1  <= r2_x1;
            r3_y1  <= r2_y1;
        end
    end

    // ---------------- stage 4: squares, cross products, pick the axis
    localparam int CRW = PW + 1 + VW;

    logic                  low_rel;
    logic [30:0]           sq;
    logic [29:0]           sqa, sqb;
    logic signed [CRW-1:0] cr_a, cr_b;
    logic                  use_x;
    logic signed [VW-1:0]  ne_s;
    logic signed [PW+1:0]  nd_s;
    logic signed [VW-1:0]  ne_abs;

    assign low_rel = (r3_ax < NW'(1 << ttis_pkg::TRIG_FRAC_BITS)) &&
                     (r3_ay < NW'(1 << ttis_pkg::TRIG_FRAC_BITS));
    assign sqa    = r3_ax[14:0] * r3_ax[14:0];
    assign sqb    = r3_ay[14:0] * r3_ay[14:0];
    assign sq     = 31'(sqa) + 31'(sqb);
    assign cr_a   = r3_dx * r3_ey;
    assign cr_b   = r3_dy * r3_ex;
    assign use_x  = r3_ax >= r3_ay;
    assign ne_s   = use_x ? r3_ex : r3_ey;
    assign nd_s   = use_x ? (PW+2)'(r3_dx) : (PW+2)'(r3_dy);
    assign ne_abs = (ne_s < 0) ? -ne_s : ne_s;

    logic                  r4_low_rel;
    logic [30:0]           r4_sq;
    logic                  r4_cross_ne;
    logic [NW-1:0]         r4_ne;
    logic signed [PW+1:0]  r4_ms;
    logic signed [VW-1:0]  r4_vx1, r4_vy1;
    logic signed [PW-1:0]  r4_x1, r4_y1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_low_rel  <= low_rel;
            r4_sq       <= sq;
            r4_cross_ne <= cr_a != cr_b;
            r4_ne       <= ne_abs[NW-1:0];
            r4_ms       <= (ne_s < 0) ? nd_s : -nd_s;
            r4_vx1      <= r3_vx1;
            r4_vy1      <= r3_vy1;
            r4_x1       <= r3_x1;
            r4_y1       <= r3_y1;
        end
    end

    // ---------------- stage 5: classify
    logic [51:0] sq_scaled;
    logic        parallel;
    logic [1:0]  status;

    assign sq_scaled = 52'(r4_sq) * ttis_pkg::PAR_SCALE;
    assign parallel  = r4_low_rel && (sq_scaled < ttis_pkg::PAR_LIM);

    always_comb begin
        if (parallel)         status = ttis_pkg::ST_PARALLEL;
        else if (r4_cross_ne) status = ttis_pkg::ST_NO_ROOT;
        else if (r4_ms < 0)   status = ttis_pkg::ST_PAST;
        else                  status = ttis_pkg::ST_HIT;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_job.status <= status;
            o_job.x1     <= r4_x1;
            o_job.y1     <= r4_y1;
            o_job.vx1    <= r4_vx1;
            o_job.vy1    <= r4_vy1;
            o_job.m      <= r4_ms[ttis_pkg::M_W-1:0];
            o_job.ne     <= r4_ne;
        end
    end

    // advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_track.valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

endmodule

`default_nettype wire

>>> src/ttis_queue.sv
// ----------------------------------------------------------------------------
// ttis_queue: job queue between front and back
// Small register FIFO; lets the front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module ttis_queue #(
    parameter int DEPTH = ttis_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  ttis_pkg::t_job      i_job,
    input  wire                 i_pop,
    output ttis_pkg::t_job      o_job,
    output ttis_pkg::t_qstat    o_qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ttis_pkg::t_job     r_mem [0:DEPTH-1];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;

    assign o_qstat.full  = r_count == CNT_W'(DEPTH);
    assign o_qstat.empty = r_count == '0;
    assign o_job         = r_mem[r_rd];

    // store item
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_qstat.full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("fill count did not follow a write");

endmodule

`default_nettype wire

>>> src/ttis_div.sv
// ----------------------------------------------------------------------------
// ttis_div: pipelined divider
// Restoring division, one quotient bit per stage, with an overflow flag when
// the quotient does not fit in Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ttis_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 28,
    parameter int Q_W   = 21
) (
    input  wire              i_clk,
    input  wire              i_en,
    input  wire  [NUM_W-1:0] i_num,
    input  wire  [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_q,
    output logic             o_ov
);

    localparam int CW = (NUM_W > DEN_W + Q_W + 1) ? NUM_W : DEN_W + Q_W + 1;

    logic [CW-1:0]    r_rem [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];
    logic             r_ov  [0:Q_W];

    // load and check for overflow
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ov[0]  <= CW'(i_num) >= (CW'(i_den) << Q_W);
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        logic [CW-1:0]  shifted;
        logic           ge;
        logic [Q_W-1:0] q_next;
        assign shifted = CW'(r_den[k-1]) << (Q_W - k);
        assign ge      = r_rem[k-1] >= shifted;
        always_comb begin
            q_next          = r_q[k-1];
            q_next[Q_W - k] = ge;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? r_rem[k-1] - shifted : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= q_next;
                r_ov[k]  <= r_ov[k-1];
            end
        end
    end

    assign o_q  = r_q[Q_W];
    assign o_ov = r_ov[Q_W];

endmodule

`default_nettype wire

>>> src/ttis_back.sv
// ----------------------------------------------------------------------------
// ttis_back: intercept time and position
// Takes jobs from the queue, forms the rounded quotients for time and for
// the first track's displacement, saturates and drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ttis_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ttis_pkg::t_job      i_job,
    input  ttis_pkg::t_qstat    i_qstat,
    output logic                o_pop,
    ttis_result_if.source       o_result
);

    localparam int PW  = ttis_pkg::POS_W;
    localparam int VW  = ttis_pkg::VEL_W;
    localparam int MW  = ttis_pkg::M_W;
    localparam int NW  = ttis_pkg::NE_W;
    localparam int DW  = ttis_pkg::DEN_W;
    localparam int QW  = ttis_pkg::DIV_Q_W;
    localparam int TNW = ttis_pkg::TNUM_W;
    localparam int PNW = ttis_pkg::PNUM_W;
    localparam int PRW = VW + MW + 1;

    logic en;
    logic r_out_valid;
    logic r_b0_v, r_b1_v;

    assign en     = !r_out_valid || o_result.ready;
    assign o_pop  = en && !i_qstat.empty;

    // ---------------- stage B0: products
    logic signed [PRW-1:0] prod_x, prod_y;
    logic signed [MW:0]    m_s;

    assign m_s    = $signed({1'b0, i_job.m});
    assign prod_x = i_job.vx1 * m_s;
    assign prod_y = i_job.vy1 * m_s;

    logic signed [PRW-1:0] r0_px, r0_py;
    logic [TNW-1:0]        r0_tnum;
    logic [DW-1:0]         r0_den;
    logic [NW-1:0]         r0_ne;
    logic [1:0]            r0_st;
    logic signed [PW-1:0]  r0_x1, r0_y1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_px   <= prod_x;
            r0_py   <= prod_y;
            r0_tnum <= TNW'(i_job.m) * TNW'(ttis_pkg::TIME_SCALE) + TNW'(i_job.ne);
            r0_den  <= {i_job.ne, 1'b0};
            r0_ne   <= i_job.ne;
            r0_st   <= i_job.status;
            r0_x1   <= i_job.x1;
            r0_y1   <= i_job.y1;
        end
    end

    // ---------------- stage B1: rounding offsets and magnitudes
    logic signed [PNW-1:0] nx, ny;
    logic [PNW-1:0]        mag_x, mag_y;

    assign nx    = $signed({r0_px[PRW-1], r0_px, 1'b0}) + $signed({{(PNW-NW){1'b0}}, r0_ne});
    assign ny    = $signed({r0_py[PRW-1], r0_py, 1'b0}) + $signed({{(PNW-NW){1'b0}}, r0_ne});
    assign mag_x = (nx < 0) ? PNW'(-nx) + PNW'(r0_den) - PNW'(1) : PNW'(nx);
    assign mag_y = (ny < 0) ? PNW'(-ny) + PNW'(r0_den) - PNW'(1) : PNW'(ny);

    logic [PNW-1:0]        r1_mx, r1_my;
    logic                  r1_nx, r1_ny;
    logic [TNW-1:0]        r1_tnum;
    logic [DW-1:0]         r1_den;
    logic [1:0]            r1_st;
    logic signed [PW-1:0]  r1_x1, r1_y1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mx   <= mag_x;
            r1_my   <= mag_y;
            r1_nx   <= nx < 0;
            r1_ny   <= ny < 0;
            r1_tnum <= r0_tnum;
            r1_den  <= r0_den;
            r1_st   <= r0_st;
            r1_x1   <= r0_x1;
            r1_y1   <= r0_y1;
        end
    end

    // ---------------- dividers
    logic [QW-1:0] tq, xq, yq;
    logic          tov, xov, yov;

    ttis_div #(.NUM_W(TNW), .DEN_W(DW), .Q_W(QW)) u_div_t (
        .i_clk (i_clk), .i_en (en), .i_num (r1_tnum), .i_den (r1_den),
        .o_q   (tq),    .o_ov (tov)
    );
    ttis_div #(.NUM_W(PNW), .DEN_W(DW), .Q_W(QW)) u_div_x (
        .i_clk (i_clk), .i_en (en), .i_num (r1_mx), .i_den (r1_den),
        .o_q   (xq),    .o_ov (xov)
    );
    ttis_div #(.NUM_W(PNW), .DEN_W(DW), .Q_W(QW)) u_div_y (
        .i_clk (i_clk), .i_en (en), .i_num (r1_my), .i_den (r1_den),
        .o_q   (yq),    .o_ov (yov)
    );

    // hold side data alongside the divider stages
    logic                 r_sv  [0:QW];
    logic [1:0]           r_sst [0:QW];
    logic signed [PW-1:0] r_sx  [0:QW];
    logic signed [PW-1:0] r_sy  [0:QW];
    logic                 r_snx [0:QW];
    logic                 r_sny [0:QW];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sst[0] <= r1_st;
            r_sx[0]  <= r1_x1;
            r_sy[0]  <= r1_y1;
            r_snx[0] <= r1_nx;
            r_sny[0] <= r1_ny;
            for (int k = 1; k <= QW; k++) begin
                r_sst[k] <= r_sst[k-1];
                r_sx[k]  <= r_sx[k-1];
                r_sy[k]  <= r_sy[k-1];
                r_snx[k] <= r_snx[k-1];
                r_sny[k] <= r_sny[k-1];
            end
        end
    end

    // ---------------- final stage: signs, offsets, saturation
    function automatic logic [PW-1:0] place(input logic signed [PW-1:0] base,
                                            input logic [QW-1:0] q,
                                            input logic ov,
                                            input logic neg);
        logic signed [PW+2:0] qs;
        logic signed [PW+2:0] sum;
        logic signed [PW+2:0] lo;
        logic signed [PW+2:0] hi;
        lo = (PW+3)'(ttis_pkg::POS_MIN);
        hi = (PW+3)'(ttis_pkg::POS_MAX);
        qs = $signed({2'b00, q[PW:0]});
        if (neg) qs = -qs;
        sum = (PW+3)'(base) + qs;
        if (ov || q[QW-1:PW+1] != '0) return neg ? ttis_pkg::POS_MIN : ttis_pkg::POS_MAX;
        else if (sum < lo)            return ttis_pkg::POS_MIN;
        else if (sum > hi)            return ttis_pkg::POS_MAX;
        else                          return sum[PW-1:0];
    endfunction

    logic hit;
    assign hit = r_sst[QW] == ttis_pkg::ST_HIT;

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_result.status <= r_sst[QW];
            if (hit) begin
                o_result.meet_time <= (tov || tq[QW-1:ttis_pkg::TIME_W] != '0) ?
                                      ttis_pkg::TIME_MAX : tq[ttis_pkg::TIME_W-1:0];
                o_result.meet_x    <= place(r_sx[QW], xq, xov, r_snx[QW]);
                o_result.meet_y    <= place(r_sy[QW], yq, yov, r_sny[QW]);
            end else begin
                o_result.meet_time <= '0;
                o_result.meet_x    <= '0;
                o_result.meet_y    <= '0;
            end
        end
    end

    assign o_result.valid = r_out_valid;

    // advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v      <= 1'b0;
            r_b1_v      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= QW; k++) r_sv[k] <= 1'b0;
        end else if (en) begin
            r_b0_v  <= !i_qstat.empty;
            r_b1_v  <= r_b0_v;
            r_sv[0] <= r_b1_v;
            for (int k = 1; k <= QW; k++) r_sv[k] <= r_sv[k-1];
            r_out_valid <= r_sv[QW];
        end
    end

endmodule

`default_nettype wire

>>> src/two_track_intercept_solver_top.sv
// ----------------------------------------------------------------------------
// two_track_intercept_solver_top: constant-velocity intercept of two tracks
// Front pipeline classifies each track pair, a queue decouples it from the
// back pipeline, which divides out intercept time and position.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  i_track    in   valid/ready    first_/second_ x, y, heading, speed
//  o_result   out  valid/ready    status, meet_x, meet_y, meet_time
//
//  One item per cycle sustained while o_result is ready; the path runs through
//  six front stages, one queue slot, two preparation stages, the 22-stage
//  bit-per-stage dividers and the output register.
//  Reset is synchronous, active low, and clears only the valid flags and
//  queue pointers. A stalled output holds the back pipeline; the front keeps
//  taking items until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module two_track_intercept_solver_top #(
    parameter int QUEUE_DEPTH = ttis_pkg::QUEUE_DEPTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    ttis_track_if.sink      i_track,
    ttis_result_if.source   o_result
);

    logic              push, pop;
    ttis_pkg::t_job    job_in, job_out;
    ttis_pkg::t_qstat  qstat;

    ttis_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_track (i_track),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (job_in)
    );

    ttis_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_qstat (qstat)
    );

    ttis_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (job_out),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

>>> verif/tb_two_track_intercept_solver_top.sv
// ----------------------------------------------------------------------------
// tb_two_track_intercept_solver_top: self-checking bench of the intercept solver
// Drives track pairs with random gaps, stalls the result side at random and
// compares every result with an intercept predicted from the same fixed-point
// rules: directed corner cases first, then mostly collinear random pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_two_track_intercept_solver_top;

    localparam int  N_RANDOM   = 630;
    localparam int  CYCLE_CAP  = 600000;
    localparam int  DRAIN_WAIT = 64;

    typedef struct {
        logic signed [ttis_pkg::POS_W-1:0]   x1;
        logic signed [ttis_pkg::POS_W-1:0]   y1;
        logic        [ttis_pkg::HEAD_W-1:0]  h1;
        logic        [ttis_pkg::SPEED_W-1:0] sp1;
        logic signed [ttis_pkg::POS_W-1:0]   x2;
        logic signed [ttis_pkg::POS_W-1:0]   y2;
        logic        [ttis_pkg::HEAD_W-1:0]  h2;
        logic        [ttis_pkg::SPEED_W-1:0] sp2;
    } t_track_pair;

    typedef struct {
        logic        [1:0]                  status;
        logic signed [ttis_pkg::POS_W-1:0]  mx;
        logic signed [ttis_pkg::POS_W-1:0]  my;
        logic        [ttis_pkg::TIME_W-1:0] tm;
    } t_meet;

    // ------------------------------------------------------------------------
    // Intercept scoreboard: predicts each pair and checks results in order
    // ------------------------------------------------------------------------
    class intercept_board;
        longint sine_q[0:900];
        t_meet  pending_meets[$];
        int     errors;

        function new();
            logic [63:0] theta, x2, term;
            longint      acc;
            for (int k = 0; k <= 900; k++) begin
                theta = (64'(k) * 64'd3373259426 + 64'd900) / 64'd1800;
                x2    = (theta * theta) >> 30;
                term  = theta;
                acc   = longint'(theta);
                for (int n = 1; n <= 10; n++) begin
                    term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) acc -= longint'(term);
                    else            acc += longint'(term);
                end
                if (acc < 0) acc = 0;
                if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
                sine_q[k] = (acc + (longint'(1) << (29 - ttis_pkg::TRIG_FRAC_BITS)))
                            >>> (30 - ttis_pkg::TRIG_FRAC_BITS);
            end
            errors = 0;
        endfunction

        // fold heading into quadrant and look up sine and cosine
        function void heading_trig(input logic [ttis_pkg::HEAD_W-1:0] h_raw,
                                   output longint s, output longint c);
            int h, q, r;
            h = int'(h_raw);
            if (h >= 3600) h -= 3600;
            q = h / 900;
            r = h % 900;
            case (q)
                0:       begin s =  sine_q[r];     c =  sine_q[900-r]; end
                1:       begin s =  sine_q[900-r]; c = -sine_q[r];     end
                2:       begin s = -sine_q[r];     c = -sine_q[900-r]; end
                default: begin s = -sine_q[900-r]; c =  sine_q[r];     end
            endcase
        endfunction

        function longint div_floor(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
            return q;
        endfunction

        function longint div_round(longint n, longint d);
            return div_floor(2 * n + d, 2 * d);
        endfunction

        function longint pos_sat(longint v);
            if (v > 131071) return 131071;
            if (v < -131072) return -131072;
            return v;
        endfunction

        function t_meet predict(t_track_pair p);
            t_meet  m;
            longint s1, c1, s2, c2, vx1, vy1, ex, ey, dx, dy, ax, ay;
            longint nd, ne, tnum, t, lim;
            m = '{status: ttis_pkg::ST_HIT, mx: '0, my: '0, tm: '0};
            lim = longint'(1) << ttis_pkg::TRIG_FRAC_BITS;
            heading_trig(p.h1, s1, c1);
            heading_trig(p.h2, s2, c2);
            vx1 = s1 * longint'(p.sp1);
            vy1 = c1 * longint'(p.sp1);
            ex  = s2 * longint'(p.sp2) - vx1;
            ey  = c2 * longint'(p.sp2) - vy1;
            dx  = longint'(p.x2) - longint'(p.x1);
            dy  = longint'(p.y2) - longint'(p.y1);
            ax  = ex < 0 ? -ex : ex;
            ay  = ey < 0 ? -ey : ey;
            if (ax < lim && ay < lim &&
                (ax * ax + ay * ay) * 1000000 <
                (longint'(1296) << (2 * ttis_pkg::TRIG_FRAC_BITS))) begin
                m.status = ttis_pkg::ST_PARALLEL;
            end else if (dx * ey - dy * ex != 0) begin
                m.status = ttis_pkg::ST_NO_ROOT;
            end else begin
                if (ax >= ay) begin nd = dx; ne = ex; end
                else          begin nd = dy; ne = ey; end
                if (ne < 0) begin nd = -nd; ne = -ne; end
                tnum = -nd * 3600 *
                       (longint'(1) << (ttis_pkg::TRIG_FRAC_BITS + ttis_pkg::TIME_FRAC_BITS));
                if (tnum < 0) begin
                    m.status = ttis_pkg::ST_PAST;
                end else begin
                    t = div_round(tnum, ne * (longint'(1) << ttis_pkg::POS_FRAC_BITS));
                    if (t > 1048575) t = 1048575;
                    m.tm = ttis_pkg::TIME_W'(t);
                    m.mx = ttis_pkg::POS_W'(pos_sat(longint'(p.x1) + div_round(-vx1 * nd, ne)));
                    m.my = ttis_pkg::POS_W'(pos_sat(longint'(p.y1) + div_round(-vy1 * nd, ne)));
                end
            end
            return m;
        endfunction

        function void note_pair(t_track_pair p);
            pending_meets = {pending_meets, predict(p)};
        endfunction

        function void check_meet(t_meet got);
            t_meet want;
            if (pending_meets.size() == 0) begin
                $display("%0t: unexpected result status=%0d x=%0d y=%0d t=%0d",
                         $time, got.status, got.mx, got.my, got.tm);
                errors++;
                return;
            end
            want = pending_meets.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.mx !== want.mx) begin
                $display("%0t: meet_x expected %0d actual %0d", $time, want.mx, got.mx);
                errors++;
            end
            if (got.my !== want.my) begin
                $display("%0t: meet_y expected %0d actual %0d", $time, want.my, got.my);
                errors++;
            end
            if (got.tm !== want.tm) begin
                $display("%0t: meet_time expected %0d actual %0d", $time, want.tm, got.tm);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count = 0;

    ttis_track_if  trk ();
    ttis_result_if res ();

    two_track_intercept_solver_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_track  (trk),
        .o_result (res)
    );

    intercept_board board = new();

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, check each accepted item
    // ------------------------------------------------------------------------
    int stall_left = 0;
    int calm_left  = 0;
    always @(posedge i_clk) begin
        t_meet got;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && res.valid && res.ready) begin
            got = '{status: res.status, mx: res.meet_x, my: res.meet_y, tm: res.meet_time};
            board.check_meet(got);
        end
        if (calm_left > 0) begin
            calm_left  <= calm_left - 1;
            res.ready  <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res.ready  <= 1'b0;
        end else begin
            res.ready <= 1'b1;
            if ($urandom_range(0, 99) < 5) calm_left <= $urandom_range(20, 80);
            else                           stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Track side
    // ------------------------------------------------------------------------
    task automatic send_pair(t_track_pair p, int gap);
        if (gap > 0) begin
            trk.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        trk.valid          <= 1'b1;
        trk.first_x        <= p.x1;
        trk.first_y        <= p.y1;
        trk.first_heading  <= p.h1;
        trk.first_speed    <= p.sp1;
        trk.second_x       <= p.x2;
        trk.second_y       <= p.y2;
        trk.second_heading <= p.h2;
        trk.second_speed   <= p.sp2;
        do @(posedge i_clk); while (!trk.ready);
        board.note_pair(p);
    endtask

    function automatic longint gcd_of(longint a, longint b);
        longint t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_track_pair mk_pair(int x1, int y1, int h1, int sp1,
                                            int x2, int y2, int h2, int sp2);
        t_track_pair p;
        p.x1  = ttis_pkg::POS_W'(x1);    p.y1 = ttis_pkg::POS_W'(y1);
        p.h1  = ttis_pkg::HEAD_W'(h1);   p.sp1 = ttis_pkg::SPEED_W'(sp1);
        p.x2  = ttis_pkg::POS_W'(x2);    p.y2 = ttis_pkg::POS_W'(y2);
        p.h2  = ttis_pkg::HEAD_W'(h2);   p.sp2 = ttis_pkg::SPEED_W'(sp2);
        return p;
    endfunction

    function automatic int rand_pos(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // headings on the same line; second displaced along that line
    function automatic t_track_pair collinear_pair(bit on_axis);
        t_track_pair p;
        longint s, c, g, ux, uy, umax, jm, j;
        int     h1, h2, x1, y1;
        h1 = on_axis ? 900 * $urandom_range(0, 3) : $urandom_range(0, 3599);
        case ($urandom_range(0, 2))
            0:       h2 = h1;
            1:       h2 = (h1 + 1800) % 3600;
            default: h2 = h1 + 3600 <= 4095 ? h1 + 3600 : (h1 + 1800) % 3600;
        endcase
        if ($urandom_range(0, 1)) h1 = h1 + 3600 <= 4095 ? h1 + 3600 : h1;
        board.heading_trig(ttis_pkg::HEAD_W'(h1), s, c);
        g  = gcd_of(s < 0 ? -s : s, c < 0 ? -c : c);
        ux = s / g;
        uy = c / g;
        umax = (ux < 0 ? -ux : ux) > (uy < 0 ? -uy : uy) ? (ux < 0 ? -ux : ux)
                                                         : (uy < 0 ? -uy : uy);
        jm = 60000 / umax;
        j  = longint'($urandom_range(0, 2 * int'(jm))) - jm;
        if ($urandom_range(0, 9) == 0) j = 0;
        x1 = rand_pos(60000);
        y1 = rand_pos(60000);
        p = mk_pair(x1, y1, h1, $urandom_range(0, 2047),
                    x1 + int'(j * ux), y1 + int'(j * uy), h2, $urandom_range(0, 2047));
        if ($urandom_range(0, 7) == 0) p.sp1 = ttis_pkg::SPEED_W'($urandom_range(2000, 2047));
        return p;
    endfunction

    function automatic t_track_pair noise_pair();
        t_track_pair p;
        p.x1  = ttis_pkg::POS_W'($urandom);   p.y1  = ttis_pkg::POS_W'($urandom);
        p.x2  = ttis_pkg::POS_W'($urandom);   p.y2  = ttis_pkg::POS_W'($urandom);
        p.h1  = ttis_pkg::HEAD_W'($urandom);  p.h2  = ttis_pkg::HEAD_W'($urandom);
        p.sp1 = ttis_pkg::SPEED_W'($urandom); p.sp2 = ttis_pkg::SPEED_W'($urandom);
        return p;
    endfunction

    initial begin
        t_track_pair dir_q[$];
        int          r;
        int          guard;

        i_rst_n         = 1'b0;
        trk.valid       = 1'b0;
        trk.first_x     = '0;  trk.first_y  = '0;
        trk.first_heading = '0; trk.first_speed = '0;
        trk.second_x    = '0;  trk.second_y = '0;
        trk.second_heading = '0; trk.second_speed = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both at rest: parallel
        dir_q = {dir_q, mk_pair(0, 0, 0, 0, 100, 100, 0, 0)};
        // same heading, same speed: parallel
        dir_q = {dir_q, mk_pair(-131072, 131071, 3599, 2047, 131071, -131072, 3599, 2047)};
        // general positions: no real root
        dir_q = {dir_q, mk_pair(131071, 131071, 450, 300, -131072, -131072, 1350, 500)};
        // head-on along north axis: hit
        dir_q = {dir_q, mk_pair(0, 0, 0, 300, 0, 2560, 1800, 300)};
        // same but behind: past
        dir_q = {dir_q, mk_pair(0, 2560, 0, 300, 0, 0, 1800, 300)};
        // east-west pursuit
        dir_q = {dir_q, mk_pair(-1000, 500, 900, 600, 4000, 500, 900, 100)};
        dir_q = {dir_q, mk_pair(4000, -500, 2700, 600, -4000, -500, 2700, 100)};
        // same place, moving apart: hit at time zero
        dir_q = {dir_q, mk_pair(1234, -4321, 0, 2047, 1234, -4321, 1800, 2047)};
        // headings that wrap past a full turn
        dir_q = {dir_q, mk_pair(0, 0, 3600, 400, 0, 1000, 4095 - 495, 400)};
        dir_q = {dir_q, mk_pair(0, 0, 4095, 10, 0, 0, 495, 10)};
        // slow closure from far away: time saturates
        dir_q = {dir_q, mk_pair(0, -131072, 0, 2, 0, 131071, 0, 1)};
        // fast first track from the edge, moving away: past
        dir_q = {dir_q, mk_pair(0, 131071, 0, 2047, 0, -131072, 0, 1)};
        dir_q = {dir_q, mk_pair(-131072, 0, 2700, 2047, 131071, 0, 2700, 1)};
        // quadrant boundaries
        dir_q = {dir_q, mk_pair(0, 0, 899, 50, 0, 0, 2699, 50)};
        dir_q = {dir_q, mk_pair(10, 10, 1800, 700, 10, -9000, 0, 20)};
        dir_q = {dir_q, mk_pair(-7, 3, 2700, 1, 9, 3, 900, 1)};
        foreach (dir_q[i]) send_pair(dir_q[i], pick_gap());

        for (int n = 0; n < N_RANDOM; n++) begin
            // once midway: hold off until every result is back
            if (n == N_RANDOM / 2) begin
                trk.valid <= 1'b0;
                guard = 0;
                do begin
                    @(posedge i_clk);
                    guard++;
                end while (board.pending_meets.size() != 0 && guard < 20000);
            end
            r = $urandom_range(0, 99);
            if (r < 30)      send_pair(collinear_pair(1'b1), pick_gap());
            else if (r < 75) send_pair(collinear_pair(1'b0), pick_gap());
            else             send_pair(noise_pair(), pick_gap());
        end
        trk.valid <= 1'b0;

        // drain, then let the pipeline settle
        while (board.pending_meets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
